/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Concurrent checks clocked on a rising edge, disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication: when ante holds, cons holds in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* hw/rtl/hktd_pkg.sv */
// ---------------------------------------------------------------------------
// hktd_pkg
// Types and constants of the Hall key threshold / debounce / SOCD block.
// ---------------------------------------------------------------------------
package hktd_pkg;

    // Field widths
    localparam int KEY_W    = 5;
    localparam int SAMPLE_W = 12;
    localparam int NOW_W    = 32;
    localparam int MAP_W    = 32;
    localparam int SETTLE_W = 8;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    // Parameter defaults
    localparam int KEY_COUNT_DEFAULT = 32;
    localparam int TIME_BITS_DEFAULT = 32;

    // Register reset values
    localparam logic [MAP_W-1:0]    ENABLED_RESET   = 32'd3284370371;
    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 12'd540;
    localparam logic [SETTLE_W-1:0] SETTLE_RESET    = 8'd5;
    localparam logic [KEY_W-1:0]    LEFT_RESET      = 5'd17;
    localparam logic [KEY_W-1:0]    RIGHT_RESET     = 5'd31;

    // Register index (byte address / 4)
    typedef enum logic [2:0] {
        REG_ENABLED_KEYS    = 3'd0,
        REG_PRESS_THRESHOLD = 3'd1,
        REG_SETTLE_MS       = 3'd2,
        REG_LEFT_KEY        = 3'd3,
        REG_RIGHT_KEY       = 3'd4
    } cfg_reg_t;

    // Scan-end information passed from the debounce stage to the output stage
    typedef struct packed {
        logic             pending;    // scan-end sample sits in the update stage
        logic             fire;       // scan-end sample completes this cycle
        logic [MAP_W-1:0] deb_map;    // debounced state after this sample
        logic             raw_left;   // left key raw-pressed in this scan
        logic             raw_right;  // right key raw-pressed in this scan
        logic             changed;    // any debounced change in this scan
    } scan_info_t;

endpackage

/* hw/rtl/hktd_time_mem.sv */
// ---------------------------------------------------------------------------
// hktd_time_mem
// Last-change time store: one write and one registered read port, with
// per-entry valid bits (unwritten entries read as zero) and write forwarding.
// ---------------------------------------------------------------------------
module hktd_time_mem
    import hktd_pkg::*;
#(
    parameter int DEPTH  = KEY_COUNT_DEFAULT,
    parameter int ADDR_W = $clog2(KEY_COUNT_DEFAULT),
    parameter int WIDTH  = TIME_BITS_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] q_reg;
    logic [WIDTH-1:0] fwd_data_reg;
    logic             fwd_reg;
    logic             vld_q_reg;
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;

    // Mark an entry valid once written
    always_comb
    begin
        vld_next = vld_reg;
        if (wr_en)
        begin
            vld_next[wr_addr] = 1'b1;
        end
    end

    // Write port and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg        <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // Valid bits and forwarding flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            fwd_reg   <= 1'b0;
            vld_q_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (rd_en)
            begin
                fwd_reg   <= wr_en && (wr_addr == rd_addr);
                vld_q_reg <= vld_reg[rd_addr];
            end
        end
    end

    // Pick forwarded data, stored data, or the reset value
    assign rd_data = fwd_reg ? fwd_data_reg : (vld_q_reg ? q_reg : '0);

endmodule

/* hw/rtl/hktd_debounce.sv */
// ---------------------------------------------------------------------------
// hktd_debounce
// Update stage: threshold compare, settle-time check against the stored
// last-change time, debounced state and per-scan raw/changed flags.
// ---------------------------------------------------------------------------
module hktd_debounce
    import hktd_pkg::*;
#(
    parameter int KEY_COUNT = KEY_COUNT_DEFAULT,
    parameter int TIME_BITS = TIME_BITS_DEFAULT,
    parameter int IDX_W     = $clog2(KEY_COUNT_DEFAULT)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // transaction entering the stage
    input  logic                 take,
    input  logic [KEY_W-1:0]     key_index,
    input  logic [SAMPLE_W-1:0]  sample,
    input  logic [NOW_W-1:0]     now_ms,
    input  logic                 scan_end,
    input  logic                 hold,
    // configuration
    input  logic [MAP_W-1:0]     enabled_keys,
    input  logic [SAMPLE_W-1:0]  press_threshold,
    input  logic [SETTLE_W-1:0]  settle_ms,
    input  logic [KEY_W-1:0]     left_key,
    input  logic [KEY_W-1:0]     right_key,
    // time store
    input  logic [TIME_BITS-1:0] rd_time,
    output logic                 wr_en,
    output logic [IDX_W-1:0]     wr_addr,
    output logic [TIME_BITS-1:0] wr_data,
    // scan end
    output scan_info_t           scan
);

    localparam int MAP_KEYS = (KEY_COUNT < MAP_W) ? KEY_COUNT : MAP_W;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic [KEY_W-1:0]     s1_key_reg;
    logic [SAMPLE_W-1:0]  s1_sample_reg;
    logic [TIME_BITS-1:0] s1_now_reg;
    logic                 s1_end_reg;

    logic [KEY_COUNT-1:0] deb_reg;
    logic [KEY_COUNT-1:0] deb_next;
    logic                 raw_left_reg;
    logic                 raw_left_next;
    logic                 raw_right_reg;
    logic                 raw_right_next;
    logic                 scan_changed_reg;
    logic                 scan_changed_next;

    logic [IDX_W-1:0]     key_idx;
    logic                 in_range;
    logic                 hit;
    logic                 want;
    logic [TIME_BITS-1:0] elapsed;
    logic                 upd;
    logic                 raw_l;
    logic                 raw_r;
    logic                 chg;
    logic                 fire;
    logic [MAP_W-1:0]     deb_map;

    // Qualify the sample and decide on a state change
    always_comb
    begin
        key_idx  = IDX_W'(s1_key_reg);
        in_range = (32'(s1_key_reg) < KEY_COUNT);
        hit      = s1_valid_reg && !hold && in_range && enabled_keys[s1_key_reg];
        want     = (s1_sample_reg > press_threshold);
        elapsed  = s1_now_reg - rd_time;
        upd      = hit && (elapsed > TIME_BITS'(settle_ms)) && (want != deb_reg[key_idx]);
    end

    // Next debounced state, raw pair flags and changed flag
    always_comb
    begin
        deb_next = deb_reg;
        if (upd)
        begin
            deb_next[key_idx] = want;
        end
        raw_l = raw_left_reg  || (hit && want && (s1_key_reg == left_key));
        raw_r = raw_right_reg || (hit && want && (s1_key_reg == right_key));
        chg   = scan_changed_reg || upd;
        fire  = s1_valid_reg && s1_end_reg && !hold;
        if (fire)
        begin
            raw_left_next     = 1'b0;
            raw_right_next    = 1'b0;
            scan_changed_next = 1'b0;
        end
        else
        begin
            raw_left_next     = raw_l;
            raw_right_next    = raw_r;
            scan_changed_next = chg;
        end
        s1_valid_next = take || (s1_valid_reg && hold);
    end

    // Map debounced state onto the fixed-width bitmap
    always_comb
    begin
        deb_map = '0;
        for (int k = 0; k < MAP_KEYS; k++)
        begin
            deb_map[k] = deb_next[k];
        end
    end

    // Write back the change time
    assign wr_en   = upd;
    assign wr_addr = key_idx;
    assign wr_data = s1_now_reg;

    assign scan.pending   = s1_valid_reg && s1_end_reg;
    assign scan.fire      = fire;
    assign scan.deb_map   = deb_map;
    assign scan.raw_left  = raw_l;
    assign scan.raw_right = raw_r;
    assign scan.changed   = chg;

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_key_reg    <= key_index;
            s1_sample_reg <= sample;
            s1_now_reg    <= TIME_BITS'(now_ms);
            s1_end_reg    <= scan_end;
        end
    end

    // Stage control and key state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            deb_reg          <= '0;
            raw_left_reg     <= 1'b0;
            raw_right_reg    <= 1'b0;
            scan_changed_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            deb_reg          <= deb_next;
            raw_left_reg     <= raw_left_next;
            raw_right_reg    <= raw_right_next;
            scan_changed_reg <= scan_changed_next;
        end
    end

endmodule

/* hw/rtl/hktd_scan_out.sv */
// ---------------------------------------------------------------------------
// hktd_scan_out
// Scan-end stage: last-input-priority cleaning of the opposing key pair,
// enable masking and the result register.
// ---------------------------------------------------------------------------
module hktd_scan_out
    import hktd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  scan_info_t       scan,
    input  logic [MAP_W-1:0] enabled_keys,
    input  logic [KEY_W-1:0] left_key,
    input  logic [KEY_W-1:0] right_key,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output logic [MAP_W-1:0] key_bitmap,
    output logic             changed
);

    logic [MAP_W-1:0] left_mask;
    logic [MAP_W-1:0] right_mask;
    logic [MAP_W-1:0] map;
    logic             use_left;
    logic             use_right;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [MAP_W-1:0] bitmap_reg;
    logic             changed_reg;
    logic             before_left_reg;
    logic             before_left_next;
    logic             before_right_reg;
    logic             before_right_next;
    logic             left_latest_reg;
    logic             left_latest_next;

    // Clean the pair and mask disabled keys
    always_comb
    begin
        left_mask  = MAP_W'(1) << left_key;
        right_mask = MAP_W'(1) << right_key;
        use_left   = scan.raw_left  && (!scan.raw_right || left_latest_reg);
        use_right  = scan.raw_right && (!scan.raw_left  || !left_latest_reg);
        map        = scan.deb_map & ~(left_mask | right_mask);
        if (use_left && scan.deb_map[left_key])
        begin
            map = map | left_mask;
        end
        if (use_right && scan.deb_map[right_key])
        begin
            map = map | right_mask;
        end
        map = map & enabled_keys;
    end

    // Advance pair history and the result register
    always_comb
    begin
        before_left_next  = before_left_reg;
        before_right_next = before_right_reg;
        left_latest_next  = left_latest_reg;
        if (scan.fire)
        begin
            if (scan.raw_left && !before_left_reg)
            begin
                left_latest_next = 1'b1;
            end
            if (scan.raw_right && !before_right_reg)
            begin
                left_latest_next = 1'b0;
            end
            before_left_next  = scan.raw_left;
            before_right_next = scan.raw_right;
        end
        out_valid_next = scan.fire || (out_valid_reg && rsp_stall);
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (scan.fire)
        begin
            bitmap_reg  <= map;
            changed_reg <= scan.changed;
        end
    end

    // Control and pair history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            before_left_reg  <= 1'b0;
            before_right_reg <= 1'b0;
            left_latest_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg    <= out_valid_next;
            before_left_reg  <= before_left_next;
            before_right_reg <= before_right_next;
            left_latest_reg  <= left_latest_next;
        end
    end

    assign rsp_valid  = out_valid_reg;
    assign key_bitmap = bitmap_reg;
    assign changed    = changed_reg;

endmodule

/* hw/rtl/hall_key_threshold_debounce_socd.sv */
// ---------------------------------------------------------------------------
// hall_key_threshold_debounce_socd
// Hall-sensor key threshold, per-key settle-time debounce and opposing-pair
// cleaning by last-input priority, emitting a key bitmap at each scan end.
// ---------------------------------------------------------------------------
//  channel  handshake                    payload
//  req      req_valid / req_stall        key_index, sample, now_ms, scan_end
//  rsp      rsp_valid / rsp_stall        key_bitmap, changed
//  cfg      psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// One transaction per cycle while req_stall is low: the time store is read in the
// accept cycle, written back by the update stage and forwarded to a same-key read.
// A result enters the rsp register as its scan-end sample leaves the update stage.
// Reset clears the valid bits of the time store at once; no clearing pass.
// A full, stalled rsp register holds a scan-end sample in the update stage and
// raises req_stall until the result is taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hall_key_threshold_debounce_socd
    import hktd_pkg::*;
#(
    parameter int KEY_COUNT = KEY_COUNT_DEFAULT,
    parameter int TIME_BITS = TIME_BITS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    // samples
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [KEY_W-1:0]    key_index,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [NOW_W-1:0]    now_ms,
    input  logic                scan_end,
    // results
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [MAP_W-1:0]    key_bitmap,
    output logic                changed
);

    localparam int IDX_W = $clog2(KEY_COUNT);

    logic [MAP_W-1:0]    enabled_reg;
    logic [SAMPLE_W-1:0] threshold_reg;
    logic [SETTLE_W-1:0] settle_reg;
    logic [KEY_W-1:0]    left_reg;
    logic [KEY_W-1:0]    right_reg;

    cfg_reg_t             cfg_sel;
    logic                 cfg_wr;
    logic                 take;
    logic                 hold;
    logic [TIME_BITS-1:0] rd_time;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [TIME_BITS-1:0] wr_data;
    scan_info_t           scan;

    // Configuration decode
    assign pready  = 1'b1;
    assign cfg_sel = cfg_reg_t'(paddr[PADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= ENABLED_RESET;
            threshold_reg <= THRESHOLD_RESET;
            settle_reg    <= SETTLE_RESET;
            left_reg      <= LEFT_RESET;
            right_reg     <= RIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_sel)
                REG_ENABLED_KEYS:    enabled_reg   <= pwdata;
                REG_PRESS_THRESHOLD: threshold_reg <= pwdata[SAMPLE_W-1:0];
                REG_SETTLE_MS:       settle_reg    <= pwdata[SETTLE_W-1:0];
                REG_LEFT_KEY:        left_reg      <= pwdata[KEY_W-1:0];
                REG_RIGHT_KEY:       right_reg     <= pwdata[KEY_W-1:0];
                default:             ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (cfg_sel)
            REG_ENABLED_KEYS:    prdata = enabled_reg;
            REG_PRESS_THRESHOLD: prdata = PDATA_W'(threshold_reg);
            REG_SETTLE_MS:       prdata = PDATA_W'(settle_reg);
            REG_LEFT_KEY:        prdata = PDATA_W'(left_reg);
            REG_RIGHT_KEY:       prdata = PDATA_W'(right_reg);
            default:             prdata = '0;
        endcase
    end

    // Hold the update stage while a result waits in a stalled register
    assign hold      = scan.pending && rsp_valid && rsp_stall;
    assign req_stall = hold;
    assign take      = req_valid && !req_stall;

    hktd_time_mem #(
        .DEPTH  (KEY_COUNT),
        .ADDR_W (IDX_W),
        .WIDTH  (TIME_BITS)
    ) u_time_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (take),
        .rd_addr (IDX_W'(key_index)),
        .rd_data (rd_time),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    hktd_debounce #(
        .KEY_COUNT (KEY_COUNT),
        .TIME_BITS (TIME_BITS),
        .IDX_W     (IDX_W)
    ) u_debounce (
        .clk             (clk),
        .rst_n           (rst_n),
        .take            (take),
        .key_index       (key_index),
        .sample          (sample),
        .now_ms          (now_ms),
        .scan_end        (scan_end),
        .hold            (hold),
        .enabled_keys    (enabled_reg),
        .press_threshold (threshold_reg),
        .settle_ms       (settle_reg),
        .left_key        (left_reg),
        .right_key       (right_reg),
        .rd_time         (rd_time),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr),
        .wr_data         (wr_data),
        .scan            (scan)
    );

    hktd_scan_out u_scan_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .scan         (scan),
        .enabled_keys (enabled_reg),
        .left_key     (left_reg),
        .right_key    (right_reg),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .key_bitmap   (key_bitmap),
        .changed      (changed)
    );

    // Input stalls only behind a full, stalled result register
    `ASSERT_IMPLIES(a_stall_cause, clk, rst_n, req_stall, rsp_valid && rsp_stall && scan.pending)
    // A completed scan always lands in the result register
    `ASSERT_NEXT(a_fire_result, clk, rst_n, scan.fire, rsp_valid)
    // No write-back while the update stage is held
    `ASSERT_IMPLIES(a_no_write_on_hold, clk, rst_n, wr_en, !hold)

endmodule

/* sim/hall_key_threshold_debounce_socd_test.sv */
// ----------------------------------------------------------------------------
// hall_key_threshold_debounce_socd_test
// Self-checking bench for the Hall key debounce block. A queue-fed driver
// sends key samples, and a monitor predicts each scan bitmap (threshold,
// settle-time debounce, left/right last-input priority) and checks every
// result in order. Phases change the registers over APB, mix directed scans,
// well-formed random scans and noise, and vary idling and back-pressure.
// ----------------------------------------------------------------------------
module hall_key_threshold_debounce_socd_test
    import hktd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 80;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [SAMPLE_W-1:0] reading;
        logic [NOW_W-1:0]    stamp;
        logic                last;
    } key_sample_t;

    typedef struct packed {
        logic [MAP_W-1:0] map;
        logic             changed;
    } scan_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                req_valid = 1'b0;
    logic                req_stall;
    logic [KEY_W-1:0]    key_index = '0;
    logic [SAMPLE_W-1:0] sample = '0;
    logic [NOW_W-1:0]    now_ms = '0;
    logic                scan_end = 1'b0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    logic [MAP_W-1:0]    key_bitmap;
    logic                changed;

    hall_key_threshold_debounce_socd u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .key_index  (key_index),
        .sample     (sample),
        .now_ms     (now_ms),
        .scan_end   (scan_end),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .key_bitmap (key_bitmap),
        .changed    (changed)
    );

    // Pending samples and expected scan bitmaps
    key_sample_t  sample_q[$];
    scan_result_t scan_results_q[$];
    int           items_sent = 0;
    int           items_taken = 0;
    int           mismatches = 0;
    int           quiet_cycles = 0;
    logic         req_took = 1'b0;

    // Idling and long hold-off control
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;

    // Predictor copy of the registers
    logic [MAP_W-1:0]    cfg_enabled   = ENABLED_RESET;
    logic [SAMPLE_W-1:0] cfg_threshold = THRESHOLD_RESET;
    logic [SETTLE_W-1:0] cfg_settle    = SETTLE_RESET;
    logic [KEY_W-1:0]    cfg_left      = LEFT_RESET;
    logic [KEY_W-1:0]    cfg_right     = RIGHT_RESET;

    // Predictor copy of the debounce and pair state
    logic [MAP_W-1:0] deb_state = '0;
    logic [NOW_W-1:0] change_stamp [32];
    logic             scan_dirty = 1'b0;
    logic             left_raw = 1'b0;
    logic             right_raw = 1'b0;
    logic             left_prev = 1'b0;
    logic             right_prev = 1'b0;
    logic             left_latest = 1'b0;

    // Stimulus-side state: intended key positions and scan time
    logic [31:0] key_held = '0;
    logic [31:0] clock_ms = '0;

    // Clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Apply one accepted sample and queue the scan bitmap on scan end
    task automatic debounce_take(input logic [KEY_W-1:0] key, input logic [SAMPLE_W-1:0] rd,
                                 input logic [NOW_W-1:0] now, input logic last);
        logic             want;
        logic [NOW_W-1:0] elapsed;
        logic [MAP_W-1:0] map;
        scan_result_t     res;
        if (cfg_enabled[key])
        begin
            want = rd > cfg_threshold;
            if (key == cfg_left && want)
                left_raw = 1'b1;
            if (key == cfg_right && want)
                right_raw = 1'b1;
            elapsed = now - change_stamp[key];
            if (elapsed > {24'd0, cfg_settle} && want != deb_state[key])
            begin
                deb_state[key]    = want;
                change_stamp[key] = now;
                scan_dirty        = 1'b1;
            end
        end
        if (last)
        begin
            // Drop the pair bits, then restore the one that wins
            map = deb_state;
            map[cfg_left]  = 1'b0;
            map[cfg_right] = 1'b0;
            if (left_raw && (!right_raw || left_latest))
                map[cfg_left] = deb_state[cfg_left];
            else if (right_raw)
                map[cfg_right] = deb_state[cfg_right];
            if (left_raw && !left_prev)
                left_latest = 1'b1;
            if (right_raw && !right_prev)
                left_latest = 1'b0;
            left_prev   = left_raw;
            right_prev  = right_raw;
            left_raw    = 1'b0;
            right_raw   = 1'b0;
            res.map     = map & cfg_enabled;
            res.changed = scan_dirty;
            scan_dirty  = 1'b0;
            scan_results_q.push_back(res);
        end
    endtask

    // Driver: offer queued samples, hold a stalled transaction
    always @(negedge clk)
    begin : drive_samples
        key_sample_t it;
        if (rst_n && (!req_valid || req_took))
        begin
            if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                it = sample_q.pop_front();
                req_valid <= 1'b1;
                key_index <= it.key;
                sample    <= it.reading;
                now_ms    <= it.stamp;
                scan_end  <= it.last;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Receiver: random stall, or a long hold-off when requested
    always @(negedge clk)
    begin : drive_stall
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else if (hold_requests != holds_served)
        begin
            holds_served = holds_served + 1;
            hold_left    = LONG_HOLD - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Monitor: check results, predict accepted samples, watch for hangs
    always @(posedge clk)
    begin : watch_ports
        scan_result_t exp;
        logic         rsp_took;
        if (rst_n)
        begin
            rsp_took = rsp_valid && !rsp_stall;
            req_took = req_valid && !req_stall;
            if (rsp_took)
            begin
                if (scan_results_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual %h %b",
                             $time, key_bitmap, changed);
                end
                else
                begin
                    exp = scan_results_q.pop_front();
                    if (key_bitmap !== exp.map)
                    begin
                        mismatches++;
                        $display("%0t: key_bitmap mismatch, expected %h, actual %h",
                                 $time, exp.map, key_bitmap);
                    end
                    if (changed !== exp.changed)
                    begin
                        mismatches++;
                        $display("%0t: changed mismatch, expected %b, actual %b",
                                 $time, exp.changed, changed);
                    end
                end
            end
            if (req_took)
            begin
                items_taken++;
                debounce_take(key_index, sample, now_ms, scan_end);
            end
            if (rsp_took || req_took)
                quiet_cycles = 0;
            else if (items_sent != items_taken || scan_results_q.size() != 0)
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
                $display("hall_key_threshold_debounce_socd_test: done, errors");
                $finish;
            end
        end
    end

    task automatic push_item(input logic [KEY_W-1:0] key, input logic [SAMPLE_W-1:0] rd,
                             input logic [NOW_W-1:0] now, input logic last);
        key_sample_t it;
        it.key     = key;
        it.reading = rd;
        it.stamp   = now;
        it.last    = last;
        sample_q.push_back(it);
        items_sent++;
    endtask

    // Reading for a key: above or at/below the threshold, sometimes a bounce
    function automatic logic [SAMPLE_W-1:0] pick_level(input logic held);
        if ($urandom_range(0, 9) == 0)
            return SAMPLE_W'($urandom_range(0, 4095));
        if (held && cfg_threshold != 12'd4095)
            return SAMPLE_W'($urandom_range(4095, int'(cfg_threshold) + 1));
        return SAMPLE_W'($urandom_range(int'(cfg_threshold), 0));
    endfunction

    // One well-formed scan: a few keys, pair keys favored, ends with scan_end
    task automatic add_scan(inout int count, input int max_keys);
        int               n;
        int               k;
        int               roll;
        logic [KEY_W-1:0] key;
        clock_ms = clock_ms + $urandom_range(0, int'(cfg_settle) / 2 + 2);
        n = $urandom_range(1, max_keys);
        for (k = 0; k < n; k++)
        begin
            roll = $urandom_range(0, 9);
            if (roll < 3)
                key = cfg_left;
            else if (roll < 6)
                key = cfg_right;
            else
                key = KEY_W'($urandom_range(0, 31));
            if ($urandom_range(0, 9) == 0)
                key_held[key] = ~key_held[key];
            push_item(key, pick_level(key_held[key]), clock_ms + $urandom_range(0, 1), k == n - 1);
            count++;
        end
    endtask

    // Random part: mostly well-formed scans, some noise with arbitrary fields
    task automatic add_random_items(input int budget);
        int added;
        added = 0;
        while (added < budget)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                push_item(KEY_W'($urandom_range(0, 31)), SAMPLE_W'($urandom_range(0, 4095)),
                          $urandom, $urandom_range(0, 3) == 0);
                added++;
            end
            else
                add_scan(added, 7);
        end
    endtask

    // Wait until every sample is taken and every result checked
    task automatic wait_idle();
        while (items_taken != items_sent || scan_results_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic write_reg(input cfg_reg_t idx, input logic [PDATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ENABLED_KEYS:    cfg_enabled   = value;
            REG_PRESS_THRESHOLD: cfg_threshold = value[SAMPLE_W-1:0];
            REG_SETTLE_MS:       cfg_settle    = value[SETTLE_W-1:0];
            REG_LEFT_KEY:        cfg_left      = value[KEY_W-1:0];
            REG_RIGHT_KEY:       cfg_right     = value[KEY_W-1:0];
            default:             ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] en, input logic [31:0] thr,
                              input logic [31:0] settle, input logic [31:0] left,
                              input logic [31:0] right);
        wait_idle();
        write_reg(REG_ENABLED_KEYS, en);
        write_reg(REG_PRESS_THRESHOLD, thr);
        write_reg(REG_SETTLE_MS, settle);
        write_reg(REG_LEFT_KEY, left);
        write_reg(REG_RIGHT_KEY, right);
    endtask

    // Main sequence
    initial
    begin : run_phases
        int i;
        int burst;
        for (i = 0; i < 32; i++)
            change_stamp[i] = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Receiver idles more than sender
        send_idle_pct = 36;
        recv_idle_pct = 67;

        // Directed scans under reset settings (pair 17/31, key 2 disabled)
        push_item(5'd0, 12'd4095, 32'd3, 1'b0);        // inside settle window
        push_item(5'd0, 12'd4095, 32'd6, 1'b1);        // press after settle
        push_item(5'd1, 12'd540, 32'd6, 1'b0);         // at threshold: released
        push_item(5'd1, 12'd541, 32'd6, 1'b0);         // just above: pressed
        push_item(5'd2, 12'd4095, 32'd6, 1'b1);        // disabled key
        push_item(5'd17, 12'd4095, 32'd10, 1'b0);      // both pair keys rise
        push_item(5'd31, 12'd4095, 32'd10, 1'b1);      // right wins
        push_item(5'd17, 12'd4095, 32'd20, 1'b0);      // only left raw
        push_item(5'd31, 12'd0, 32'd20, 1'b1);
        push_item(5'd31, 12'd4095, 32'd30, 1'b0);      // right rises again
        push_item(5'd17, 12'd4095, 32'd30, 1'b1);
        push_item(5'd0, 12'd0, 32'd40, 1'b1);          // neither pair key raw
        push_item(5'd1, 12'd0, 32'hFFFF_FFFF, 1'b1);   // release at top of time
        push_item(5'd1, 12'd4095, 32'd2, 1'b1);        // wrapped, still settling
        push_item(5'd1, 12'd4095, 32'd5, 1'b1);        // wrapped, settled
        push_item(5'd31, 12'd2730, 32'h5555_5555, 1'b0);
        push_item(5'd17, 12'd1365, 32'hAAAA_AAAA, 1'b1);
        push_item(5'd24, 12'd4095, 32'hAAAA_AAB0, 1'b1);
        wait_idle();

        clock_ms = 32'd100;
        add_random_items(240);

        // All keys, threshold and settle at their floor
        set_config(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd31);
        add_random_items(120);
        wait_idle();  // sender pause until every result is back
        add_random_items(120);

        // Sender idles more than receiver
        send_idle_pct = 67;
        recv_idle_pct = 36;

        // Nothing enabled, threshold and settle at their ceiling
        set_config(32'h0000_0000, 32'd4095, 32'd255, 32'd31, 32'd0);
        add_random_items(60);

        // Same key on both sides of the pair
        set_config(32'hA5A5_5A5A, 32'd1000, 32'd10, 32'd5, 32'd5);
        add_random_items(250);

        // No idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;

        set_config(32'hFFFF_FFFF, 32'd540, 32'd5, 32'd3, 32'd12);
        add_random_items(120);
        // Long receiver hold-off while scan ends keep arriving
        hold_requests++;
        for (burst = 0; burst < 60; burst++)
            add_scan(burst, 1);
        add_random_items(80);

        // Random settings with time running across the wrap
        set_config($urandom, $urandom_range(200, 3800), $urandom_range(0, 20),
                   $urandom_range(0, 31), $urandom_range(0, 31));
        clock_ms = 32'hFFFF_FF00;
        add_random_items(300);

        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("hall_key_threshold_debounce_socd_test: done, clean");
        else
            $display("hall_key_threshold_debounce_socd_test: done, errors");
        $finish;
    end

endmodule
